// ----- src/linear_recurrence_matrix_power_mod_assert.svh -----
// ----------------------------------------------------------------------------
// lrmp assertion macros
// shared macros for concurrent checks on clk with asynchronous reset
// ----------------------------------------------------------------------------
`ifndef LINEAR_RECURRENCE_MATRIX_POWER_MOD_ASSERT_SVH
`define LINEAR_RECURRENCE_MATRIX_POWER_MOD_ASSERT_SVH
// implication checked every clock while out of reset
`define LRMP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lrmp check failed");
// next-cycle implication
`define LRMP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lrmp check failed");
`endif

// ----- src/lrmp_pkg.sv -----
// ----------------------------------------------------------------------------
// lrmp package
// widths, state encodings and control structs of the matrix power block
// ----------------------------------------------------------------------------
package lrmp_pkg;
	localparam int A_W = 15;
	localparam int B_W = 30;
	localparam int N_W = 31;
	localparam int M_W = 15;

	typedef enum logic [1:0] {
		MM_IDLE,
		MM_RUN,
		MM_FIX,
		MM_DONE
	} mm_state_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RB,
		ST_AM,
		ST_AA,
		ST_INIT,
		ST_MUL,
		ST_NEXT,
		ST_ROW,
		ST_OUT
	} top_state_t;

	typedef struct packed {
		logic start;
	} mm_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mm_sts_t;
endpackage

// ----- src/lrmp_if.sv -----
// ----------------------------------------------------------------------------
// lrmp stream interface
// valid/ready channel carrying one payload item
// ----------------------------------------------------------------------------
interface lrmp_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/linear_recurrence_matrix_power_mod.sv -----
// ----------------------------------------------------------------------------
// linear_recurrence_matrix_power_mod
// S(n) mod m of a second-order recurrence by 2x2 matrix power
// ----------------------------------------------------------------------------
// One item at a time. Every product goes through one bit-serial modular
// multiply-add that consumes one multiplier bit per cycle over a YW-bit
// operand (YW = max(30, MOD_BITS)). An item runs four setup products
// (b mod m, a mod m, a*a, 2a), then for each of the EXP_BITS exponent bits a
// squaring of eight products plus eight more when that bit of n-1 is set,
// then two products for the final row; a sequencing state comes before
// each pass and before the row, and there are p = EXP_BITS +
// popcount(n-1) passes in all. A zero modulus skips every product and
// yields 0. The result waits in an output register, so the next item is
// accepted at once and only stalls at its end if that result is still
// untaken.
module linear_recurrence_matrix_power_mod #(
	parameter int MOD_BITS = 15,
	parameter int EXP_BITS = 31
) (
	input  logic clk,
	input  logic arst_n,
	lrmp_if.sink   in_ch,
	lrmp_if.source out_ch
);
	import lrmp_pkg::*;

	localparam int YW = (B_W > MOD_BITS) ? B_W : MOD_BITS;
	localparam int EW = $clog2(EXP_BITS + 1);

	top_state_t            state_q, state_d;
	logic [MOD_BITS-1:0]   m_q, a2_q, bm_q, am_q, aa_q;
	logic [MOD_BITS-1:0]   b_q [4];
	logic [MOD_BITS-1:0]   c_q [4];
	logic [MOD_BITS-1:0]   t_q [4];
	logic [B_W-1:0]        braw_q;
	logic [A_W-1:0]        in_a_q;
	logic [EXP_BITS-1:0]   e_q;
	logic [EW-1:0]         bit_q;
	logic [3:0]            step_q;
	logic                  sq_q;
	logic                  mulp_q;
	logic                  out_v_q;
	logic [MOD_BITS-1:0]   out_q;
	logic                  m_zero_q;
	logic                  go;
	logic                  out_free;

	mm_ctl_t               mctl;
	mm_sts_t               msts;
	logic [MOD_BITS-1:0]   mx, mz, mr;
	logic [YW-1:0]         my;
	logic [MOD_BITS-1:0]   one_m, p_e [4], q_e [4];
	logic [MOD_BITS:0]     sum;
	logic [MOD_BITS-1:0]   neg_aa, row0;

	lrmp_mulmod #(.MOD_BITS(MOD_BITS), .Y_BITS(YW)) u_mm (
		.clk, .arst_n, .ctl(mctl), .sts(msts),
		.x(mx), .y(my), .z(mz), .m(m_q), .r(mr)
	);

	// mulp selects acc*base
	always_comb begin
		one_m    = (m_q == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
		neg_aa   = (aa_q == '0) ? '0 : m_q - aa_q;
		sum      = {1'b0, aa_q} + {1'b0, bm_q};
		if (sum >= {1'b0, m_q}) sum = sum - {1'b0, m_q};
		row0     = MOD_BITS'(sum);
		out_free = !out_v_q || out_ch.ready;
		for (int i = 0; i < 4; i++) begin
			p_e[i] = mulp_q ? c_q[i] : b_q[i];
			q_e[i] = b_q[i];
		end
	end

	// product element k = step[2:1], term = step[0]; row i = k[1], col j = k[0]
	always_comb begin
		mx = '0;
		my = '0;
		mz = '0;
		case (state_q)
			ST_RB: begin
				mx = one_m;
				my = YW'(braw_q);
			end
			ST_AM: begin
				mx = one_m;
				my = YW'(in_a_q);
			end
			ST_AA: begin
				mx = am_q;
				my = YW'(am_q);
			end
			ST_INIT: begin
				mx = one_m;
				my = YW'({in_a_q, 1'b0});
			end
			ST_MUL: begin
				mx = p_e[{step_q[2], step_q[0]}];
				my = YW'(q_e[{step_q[0], step_q[1]}]);
				mz = step_q[0] ? t_q[step_q[2:1]] : '0;
			end
			ST_ROW: begin
				// first row entry doubled through the multiplier operand
				mx = step_q[0] ? a2_q : row0;
				my = YW'(step_q[0] ? {1'b0, c_q[3]} : {c_q[1], 1'b0});
				mz = step_q[0] ? t_q[0] : '0;
			end
			default: ;
		endcase
	end

	always_comb begin
		go = !(state_q inside {ST_IDLE, ST_NEXT, ST_OUT}) && !msts.busy;
		mctl.start = go && !msts.done && !m_zero_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_ch.valid) state_d = ST_RB;
			ST_RB:   if (msts.done) state_d = ST_AM;
			ST_AM:   if (msts.done) state_d = ST_AA;
			ST_AA:   if (msts.done) state_d = ST_INIT;
			ST_INIT: if (msts.done) state_d = ST_NEXT;
			ST_MUL:  if (msts.done && step_q == 4'd7) state_d = ST_NEXT;
			ST_NEXT: begin
				if (bit_q == EW'(EXP_BITS)) state_d = ST_ROW;
				else state_d = ST_MUL;
			end
			ST_ROW:  if (msts.done && step_q == 4'd1) state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		if (m_zero_q && state_q == ST_RB) state_d = ST_OUT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
			step_q  <= '0;
			bit_q   <= '0;
			sq_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && out_free) out_v_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready) out_v_q <= 1'b0;
			if (state_q == ST_IDLE) begin
				step_q <= '0;
				bit_q  <= '0;
				sq_q   <= 1'b0;
			end else if (state_q == ST_NEXT) begin
				step_q <= '0;
				if (bit_q != EW'(EXP_BITS)) begin
					// multiply pass when bit set, then square and move on
					if (!sq_q && e_q[0]) begin
						sq_q <= 1'b1;
					end else begin
						sq_q  <= 1'b0;
						bit_q <= bit_q + 1'b1;
					end
				end
			end else if ((state_q == ST_MUL || state_q == ST_ROW) && msts.done) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// capture item fields, setup products, pass results and output
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			in_a_q   <= in_ch.data.base_a;
			braw_q   <= in_ch.data.radicand_b;
			e_q      <= EXP_BITS'(in_ch.data.index_n - 1'b1);
			m_q      <= in_ch.data.modulus;
			m_zero_q <= (in_ch.data.modulus == '0);
		end
		if (state_q == ST_RB && msts.done) bm_q <= mr;
		if (state_q == ST_AM && msts.done) am_q <= mr;
		if (state_q == ST_AA && msts.done) aa_q <= mr;
		if (state_q == ST_INIT && msts.done) begin
			a2_q   <= mr;
			b_q[0] <= mr;
			b_q[1] <= one_m;
			// b - a*a mod m
			b_q[2] <= (bm_q >= aa_q) ? bm_q - aa_q : bm_q + neg_aa;
			b_q[3] <= '0;
			c_q[0] <= one_m;
			c_q[1] <= '0;
			c_q[2] <= '0;
			c_q[3] <= one_m;
		end
		if (state_q == ST_NEXT) mulp_q <= !sq_q && e_q[0];
		if (state_q == ST_NEXT && bit_q != EW'(EXP_BITS) && (sq_q || !e_q[0]))
			e_q <= e_q >> 1;
		if ((state_q == ST_MUL || state_q == ST_ROW) && msts.done)
			t_q[step_q[2:1]] <= mr;
		if (state_q == ST_MUL && msts.done && step_q == 4'd7) begin
			for (int i = 0; i < 4; i++) begin
				if (mulp_q) c_q[i] <= (i == 3) ? mr : t_q[i];
				else b_q[i] <= (i == 3) ? mr : t_q[i];
			end
		end
		if (state_q == ST_OUT && out_free) out_q <= m_zero_q ? '0 : t_q[0];
	end

	always_comb begin
		in_ch.ready  = (state_q == ST_IDLE);
		out_ch.valid = out_v_q;
		out_ch.data  = out_q;
	end

	`include "linear_recurrence_matrix_power_mod_assert.svh"
	`LRMP_ASSERT_IMP(a_no_accept_busy, state_q != ST_IDLE, !in_ch.ready)
	`LRMP_ASSERT_NEXT(a_out_set, state_q == ST_OUT, out_ch.valid)
	`LRMP_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_q))
endmodule

// ----- src/lrmp_mulmod.sv -----
// ----------------------------------------------------------------------------
// lrmp bit-serial modular multiply
// computes (x * y + z) mod m one multiplier bit per cycle, msb first
// ----------------------------------------------------------------------------
module lrmp_mulmod #(
	parameter int MOD_BITS = 15,
	parameter int Y_BITS = 30
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lrmp_pkg::mm_ctl_t             ctl,
	output lrmp_pkg::mm_sts_t             sts,
	input  logic [MOD_BITS-1:0]           x,
	input  logic [Y_BITS-1:0]             y,
	input  logic [MOD_BITS-1:0]           z,
	input  logic [MOD_BITS-1:0]           m,
	output logic [MOD_BITS-1:0]           r
);
	import lrmp_pkg::*;

	localparam int CW = $clog2(Y_BITS + 1);

	mm_state_t             state_q, state_d;
	logic [CW-1:0]         cnt_q;
	logic [Y_BITS-1:0]     y_q;
	logic [MOD_BITS-1:0]   x_q, m_q, acc_q, z_q;
	logic [MOD_BITS+1:0]   dbl, dbl_r, add, add_r;

	// acc < m: 2acc+x < 3m, two conditional subtracts
	always_comb begin
		dbl   = {1'b0, acc_q, 1'b0} + {2'b00, (y_q[Y_BITS-1] ? x_q : {MOD_BITS{1'b0}})};
		dbl_r = (dbl >= {2'b00, m_q}) ? dbl - {2'b00, m_q} : dbl;
		dbl_r = (dbl_r >= {2'b00, m_q}) ? dbl_r - {2'b00, m_q} : dbl_r;
		add   = {2'b00, acc_q} + {2'b00, z_q};
		add_r = (add >= {2'b00, m_q}) ? add - {2'b00, m_q} : add;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			MM_IDLE: if (ctl.start) state_d = MM_RUN;
			MM_RUN:  if (cnt_q == CW'(Y_BITS - 1)) state_d = MM_FIX;
			MM_FIX:  state_d = MM_DONE;
			MM_DONE: state_d = ctl.start ? MM_RUN : MM_IDLE;
			default: state_d = MM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MM_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == MM_RUN) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start && (state_q == MM_IDLE || state_q == MM_DONE)) begin
			x_q   <= x;
			y_q   <= y;
			z_q   <= z;
			m_q   <= m;
			acc_q <= '0;
		end else if (state_q == MM_RUN) begin
			acc_q <= dbl_r[MOD_BITS-1:0];
			y_q   <= {y_q[Y_BITS-2:0], 1'b0};
		end else if (state_q == MM_FIX) begin
			acc_q <= add_r[MOD_BITS-1:0];
		end
	end

	always_comb begin
		sts.busy = (state_q == MM_RUN) || (state_q == MM_FIX);
		sts.done = (state_q == MM_DONE);
		r        = acc_q;
	end

	`include "linear_recurrence_matrix_power_mod_assert.svh"
	`LRMP_ASSERT_NEXT(a_fix_done, state_q == MM_FIX, state_q == MM_DONE)
	`LRMP_ASSERT_IMP(a_acc_red, state_q == MM_DONE && m_q != '0, acc_q < m_q)
	`LRMP_ASSERT_IMP(a_busy_done, sts.busy, !sts.done)
endmodule

// ----- tb/linear_recurrence_matrix_power_mod_tb.sv -----
// ----------------------------------------------------------------------------
// linear_recurrence_matrix_power_mod testbench
// drives a, b, n, m items through the matrix power block and checks each
// term S(n) mod m against a square-and-multiply predictor, with random
// sender bursts and receiver stalls
// ----------------------------------------------------------------------------
module linear_recurrence_matrix_power_mod_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lrmp_pkg::*;

	typedef struct packed {
		logic [A_W-1:0] base_a;
		logic [B_W-1:0] radicand_b;
		logic [N_W-1:0] index_n;
		logic [M_W-1:0] modulus;
	} term_req_t;

	typedef struct packed {
		logic [M_W-1:0] term_mod;
	} term_rsp_t;

	typedef longint unsigned mat_t [2][2];

	localparam int EXP_W = 31;
	localparam int IDLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit failed = 1'b0;
	logic [M_W-1:0] term_q [$];
	int idle_cycles = 0;
	bit in_hit, out_hit;

	lrmp_if #(.T(term_req_t)) in_ch ();
	lrmp_if #(.T(term_rsp_t)) out_ch ();

	linear_recurrence_matrix_power_mod u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #4 clk = ~clk;

	function automatic mat_t mat_mul_mod(mat_t p, mat_t q, longint unsigned m);
		mat_t r;
		for (int i = 0; i < 2; i++)
			for (int k = 0; k < 2; k++)
				r[i][k] = ((p[i][0] * q[0][k]) % m + (p[i][1] * q[1][k]) % m) % m;
		return r;
	endfunction

	function automatic logic [M_W-1:0] recur_term(term_req_t t);
		longint unsigned a, b, m, expo, aa, bm;
		mat_t acc, step, row;
		a = t.base_a;
		b = t.radicand_b;
		m = t.modulus;
		if (m == 0)
			return '0;
		expo = (longint'(t.index_n) - 1) & ((64'd1 << EXP_W) - 1);
		aa = (a * a) % m;
		bm = b % m;
		step[0][0] = (2 * a) % m;
		step[0][1] = 1 % m;
		step[1][0] = (bm + m - aa) % m;
		step[1][1] = 0;
		acc[0][0] = 1 % m;
		acc[0][1] = 0;
		acc[1][0] = 0;
		acc[1][1] = 1 % m;
		for (int i = 0; i < EXP_W; i++) begin
			if (expo[i])
				acc = mat_mul_mod(acc, step, m);
			step = mat_mul_mod(step, step, m);
		end
		row[0][0] = (2 * ((aa + bm) % m)) % m;
		row[0][1] = (2 * a) % m;
		row[1][0] = 0;
		row[1][1] = 0;
		row = mat_mul_mod(row, acc, m);
		return row[0][1][M_W-1:0];
	endfunction

	task automatic send_item(term_req_t t);
		bit hit;
		in_ch.valid <= 1'b1;
		in_ch.data <= t;
		forever begin
			@(negedge clk);
			hit = in_ch.ready;
			@(posedge clk);
			if (hit)
				break;
		end
		term_q.push_back(recur_term(t));
	endtask

	task automatic send_gap();
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic term_req_t mk_req(int a, int b, int n, int m);
		term_req_t t;
		t.base_a = A_W'(a);
		t.radicand_b = B_W'(b);
		t.index_n = N_W'(n);
		t.modulus = M_W'(m);
		return t;
	endfunction

	task automatic test_directed();
		send_item(mk_req(1, 1, 1, 7));
		send_item(mk_req(1, 1, 2, 7));
		send_item(mk_req(3, 5, 5, 1000));
		send_item(mk_req(32767, 30'h3FFFFFFF, 31'h7FFFFFFF, 32767));
		send_item(mk_req(32767, 1, 1, 32767));
		send_item(mk_req(1, 30'h3FFFFFFF, 2, 32767));
		send_item(mk_req(12345, 999, 1000, 1));
		send_item(mk_req(12345, 999, 1000, 0));
		send_item(mk_req(0, 0, 0, 0));
		send_item(mk_req(77, 123, 0, 32749));
		send_item(mk_req(0, 0, 5, 13));
		send_item(mk_req(100, 9999, 31'h40000000, 2));
		send_item(mk_req(5, 24, 31'h55555555, 32767));
		send_item(mk_req(32767, 0, 31'h2AAAAAAA, 16384));
		send_item(mk_req(2, 3, 10, 32767));
		send_item(mk_req(32767, 30'h3FFFFFFF, 3, 3));
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_random(int count);
		term_req_t t;
		int burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			t.base_a = $urandom_range(0, 7) == 0 ? A_W'($urandom_range(0, 3)) :
				A_W'($urandom);
			t.radicand_b = B_W'($urandom);
			case ($urandom_range(0, 3))
				0: t.index_n = N_W'($urandom_range(0, 40));
				default: t.index_n = N_W'($urandom);
			endcase
			case ($urandom_range(0, 7))
				0: t.modulus = M_W'($urandom_range(0, 7));
				1: t.modulus = M_W'(32767 - $urandom_range(0, 3));
				default: t.modulus = M_W'($urandom);
			endcase
			if (burst == 0) begin
				send_gap();
				burst = $urandom_range(1, 12);
			end
			if (i == count / 2) begin
				in_ch.valid <= 1'b0;
				wait (term_q.size() == 0);
				@(posedge clk);
			end
			send_item(t);
			burst--;
		end
		in_ch.valid <= 1'b0;
	endtask

	// receiver stall pattern, with ready forced high on randomly chosen cycles
	always @(posedge clk) begin
		logic [7:0] pat;
		pat = 8'($urandom);
		if ($urandom_range(0, 63) < 20)
			out_ch.ready <= 1'b1;
		else
			out_ch.ready <= pat[2] | pat[5];
	end

	always @(negedge clk) begin
		in_hit = in_ch.valid && in_ch.ready;
		out_hit = out_ch.valid && out_ch.ready;
		if (out_hit && arst_n) begin
			if (term_q.size() == 0) begin
				failed = 1'b1;
				$display("%0t: unexpected item term_mod=%0d", $realtime,
					out_ch.data.term_mod);
			end else begin
				logic [M_W-1:0] want;
				want = term_q.pop_front();
				if (out_ch.data.term_mod !== want) begin
					failed = 1'b1;
					$display("%0t: term_mod expected %0d actual %0d", $realtime,
						want, out_ch.data.term_mod);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || in_hit || out_hit)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("linear_recurrence_matrix_power_mod_tb NOT OK");
			$finish;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(570);
		wait (term_q.size() == 0);
		repeat (100) @(posedge clk);
		if (!failed && term_q.size() == 0)
			$display("linear_recurrence_matrix_power_mod_tb OK");
		else
			$display("linear_recurrence_matrix_power_mod_tb NOT OK");
		$finish;
	end
endmodule
